// File: design/murmur3_32_stream_hash_defines.svh
// Assertion macros for the MurmurHash3 stream hasher.
// No dependencies; included by the top level only.
`ifndef MURMUR3_32_STREAM_HASH_DEFINES_SVH
`define MURMUR3_32_STREAM_HASH_DEFINES_SVH

// Clocked property with async active-low reset disable and a fixed message.
`define M3SH_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("m3sh assertion failed");

// Same, with a caller-supplied message string.
`define M3SH_ASSERT_MSG(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

// File: design/m3sh_pkg.sv
// Constants and helper functions for the MurmurHash3 x86_32 stream hasher.
// No dependencies.
package m3sh_pkg;

    localparam logic [31:0] MM_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MM_C2  = 32'h1b873593;
    localparam logic [31:0] MM_ADD = 32'he6546b64;
    localparam logic [31:0] MM_F1  = 32'h85ebca6b;
    localparam logic [31:0] MM_F2  = 32'hc2b2ae35;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned COUNT_W = 3;
    localparam int unsigned TDATA_W = 72;  // 32 + 3 + 32 bits, padded to bytes

    typedef logic [WORD_W-1:0] word_t;

    function automatic word_t rotl15(input word_t v);
        return {v[16:0], v[31:17]};
    endfunction

    function automatic word_t rotl13(input word_t v);
        return {v[18:0], v[31:19]};
    endfunction

    // Keep only the valid low bytes of a short final word.
    function automatic word_t byte_mask(input word_t v, input logic [COUNT_W-1:0] cnt);
        word_t m;
        unique case (cnt)
            3'd1:    m = 32'h0000_00ff;
            3'd2:    m = 32'h0000_ffff;
            3'd3:    m = 32'h00ff_ffff;
            3'd0:    m = 32'h0000_0000;
            default: m = 32'hffff_ffff;
        endcase
        return v & m;
    endfunction

endpackage

// File: design/murmur3_32_stream_hash.sv
// murmur3_32_stream_hash: streaming MurmurHash3 x86_32, one shared 32x32 multiplier.
// Depends on m3sh_pkg and murmur3_32_stream_hash_defines.svh.
//
//   channel   dir  fields (lsb first)
//   s_axis    in   tdata: data_word[31:0], byte_count[34:32], seed[66:35]; tlast: last_word
//   m_axis    out  tdata: hash_value[31:0]
//
// A request is accepted in idle, then passes twice through the multiplier (k*C1, k*C2),
// then through the hash update. Zero-byte requests skip the mix. A request ending a
// message adds two finalizer multiplies, then the output load. The multiplier sets the pace.
// Reset clears the sequencer, the message state and the output valid.
// The input side is ready whenever the sequencer is idle, even while a hash waits on
// m_axis; only the output load step stalls if that hash has not been taken.
`include "murmur3_32_stream_hash_defines.svh"

module murmur3_32_stream_hash
    import m3sh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [TDATA_W-1:0]   s_axis_tdata,   // data_word, byte_count, seed, zero pad
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [WORD_W-1:0]    m_axis_tdata    // hash_value
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_K1   = 3'd1;
    localparam logic [2:0] ST_K2   = 3'd2;
    localparam logic [2:0] ST_HUPD = 3'd3;
    localparam logic [2:0] ST_F1   = 3'd4;
    localparam logic [2:0] ST_F2   = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]   state_reg, state_next;
    logic         in_msg_reg;
    logic         final_reg;
    logic         full_reg;
    word_t        word_reg;
    word_t        k_reg, k_next;
    word_t        hash_reg, hash_next;
    word_t        total_reg;
    word_t        out_data_reg;
    logic         out_valid_reg;

    word_t        in_word, in_seed;
    logic [COUNT_W-1:0] in_count, count_clamped;
    logic         in_accept, in_final;
    logic         out_load;

    word_t        mul_a, mul_b, mul_p;
    word_t        mix_t, mix_r, fin_x;

    assign in_word  = s_axis_tdata[31:0];
    assign in_count = s_axis_tdata[34:32];
    assign in_seed  = s_axis_tdata[66:35];

    assign count_clamped = in_count[2] ? 3'd4 : in_count;
    assign in_final      = s_axis_tlast || !in_count[2];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Shared multiplier operand select
    assign fin_x = hash_reg ^ total_reg;
    always_comb
    begin
        mul_a = word_reg;
        mul_b = MM_C1;
        unique case (state_reg)
            ST_K2:
            begin
                mul_a = rotl15(k_reg);
                mul_b = MM_C2;
            end
            ST_F1:
            begin
                mul_a = fin_x ^ (fin_x >> 16);
                mul_b = MM_F1;
            end
            ST_F2:
            begin
                mul_a = k_reg ^ (k_reg >> 13);
                mul_b = MM_F2;
            end
            default:
            begin
                mul_a = word_reg;
                mul_b = MM_C1;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Hash update: rotate and times-5-plus-constant for full words only
    assign mix_t = hash_reg ^ k_reg;
    assign mix_r = rotl13(mix_t);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        hash_next  = hash_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                    state_next = (count_clamped == 3'd0) ? ST_F1 : ST_K1;
            end
            ST_K1:
            begin
                k_next     = mul_p;
                state_next = ST_K2;
            end
            ST_K2:
            begin
                k_next     = mul_p;
                state_next = ST_HUPD;
            end
            ST_HUPD:
            begin
                hash_next  = full_reg ? ((mix_r << 2) + mix_r + MM_ADD) : mix_t;
                state_next = final_reg ? ST_F1 : ST_IDLE;
            end
            ST_F1:
            begin
                k_next     = mul_p;
                state_next = ST_F2;
            end
            ST_F2:
            begin
                k_next     = mul_p;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_msg_reg    <= 1'b0;
            hash_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
            begin
                hash_reg   <= in_msg_reg ? hash_reg : in_seed;
                total_reg  <= (in_msg_reg ? total_reg : '0) + WORD_W'(count_clamped);
                in_msg_reg <= !in_final;
            end
            else
            begin
                hash_reg <= hash_next;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        if (in_accept)
        begin
            word_reg  <= byte_mask(in_word, count_clamped);
            final_reg <= in_final;
            full_reg  <= in_count[2];
        end
        if (out_load)
            out_data_reg <= k_reg ^ (k_reg >> 16);
    end

    `M3SH_ASSERT(a_out_hold, clk, rst_n,
        (state_reg == ST_OUT && out_valid_reg && !m_axis_tready) |=> (state_reg == ST_OUT))
    `M3SH_ASSERT(a_empty_to_fin, clk, rst_n,
        (in_accept && count_clamped == 3'd0) |=> (state_reg == ST_F1))
    `M3SH_ASSERT_MSG(a_mid_msg, clk, rst_n,
        (state_reg == ST_HUPD && !final_reg) |=> (state_reg == ST_IDLE && in_msg_reg),
        "non-final word did not return to idle inside a message")
    `M3SH_ASSERT_MSG(a_out_load, clk, rst_n,
        out_load |=> (m_axis_tvalid && state_reg == ST_IDLE),
        "output load did not raise m_axis_tvalid")

endmodule
